/* hdl/mlfq_pkg.sv */
// ----------------------------------------------------------------------------
// mlfq_pkg
// shared constants and types of the feedback scheduler
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int MAX_JOBS    = 16;
  localparam int NUM_LEVELS  = 4;
  localparam int SLOT_W      = $clog2(MAX_JOBS);
  localparam int LVL_W       = $clog2(NUM_LEVELS);
  localparam int CNT_W       = $clog2(MAX_JOBS + 1);
  localparam int DEPTH       = NUM_LEVELS * MAX_JOBS;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int ID_W        = 4;
  localparam int WORK_W      = 16;
  localparam int ENTRY_W     = ID_W + WORK_W;

  localparam logic       REQ_ARRIVAL = 1'b0;
  localparam logic       REQ_TICK    = 1'b1;
  localparam logic [1:0] ST_ACCEPT   = 2'd0;
  localparam logic [1:0] ST_DROP     = 2'd1;
  localparam logic [1:0] ST_RAN      = 2'd2;
  localparam logic [1:0] ST_IDLE     = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [ID_W-1:0]   job_id;
    logic [WORK_W-1:0] service_demand;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   run_job;
    logic [1:0]        run_level;
    logic [WORK_W-1:0] remaining_work;
    logic              job_finished;
  } out_item_t;

endpackage

/* hdl/mlfq_if.sv */
// ----------------------------------------------------------------------------
// mlfq_in_if / mlfq_out_if
// valid/ready channels of the scheduler
// ----------------------------------------------------------------------------
interface mlfq_in_if;
  logic              valid;
  logic              ready;
  mlfq_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mlfq_out_if;
  logic               valid;
  logic               ready;
  mlfq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/multilevel_feedback_queue_scheduler.sv */
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// four-level feedback scheduler with a one-tick quantum
// ----------------------------------------------------------------------------
// The back end handles each item in turn: it first updates the level
// counters and writes the store, then does the registered read of the chosen
// queue head out of the shared store memory, then forms the result. A two
// entry input queue takes the next item meanwhile; the back end takes no new
// item until it is through with the last one and the result can be taken.
module multilevel_feedback_queue_scheduler (
  input  logic clk,
  input  logic rst_n,
  mlfq_in_if.sink    in_ch,
  mlfq_out_if.source out_ch
);
  logic               q_valid, q_pop;
  mlfq_pkg::in_item_t q_data;

  mlfq_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  mlfq_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data),
    .q_pop(q_pop), .out_ch(out_ch)
  );
endmodule

/* hdl/mlfq_ram.sv */
// ----------------------------------------------------------------------------
// mlfq_ram
// generic single-write ram with registered read
// ----------------------------------------------------------------------------
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/mlfq_front.sv */
// ----------------------------------------------------------------------------
// mlfq_front
// input skid queue, two entries, decouples acceptance from execution
// ----------------------------------------------------------------------------
module mlfq_front (
  input  logic               clk,
  input  logic               rst_n,
  mlfq_in_if.sink            in_ch,
  output logic               q_valid,
  output mlfq_pkg::in_item_t q_data,
  input  logic               q_pop
);
  mlfq_pkg::in_item_t buf_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_data      = buf_r[rd_r];

  always_comb begin
    rd_nxt  = rd_r ^ q_pop;
    wr_nxt  = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      buf_r[wr_r] <= in_ch.data;
    end
  end
endmodule

/* hdl/mlfq_back.sv */
// ----------------------------------------------------------------------------
// mlfq_back
// level queues and tick execution, three-step sequencer per item
// ----------------------------------------------------------------------------
module mlfq_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  mlfq_pkg::in_item_t q_data,
  output logic               q_pop,
  mlfq_out_if.source         out_ch
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam int NL = mlfq_pkg::NUM_LEVELS;
  localparam int SW = mlfq_pkg::SLOT_W;
  localparam int LW = mlfq_pkg::LVL_W;
  localparam int CW = mlfq_pkg::CNT_W;
  localparam int WW = mlfq_pkg::WORK_W;

  logic [1:0]  state_r, state_nxt;
  logic [SW-1:0] head_r [NL];
  logic [CW-1:0] count_r [NL];
  logic [CW-1:0] cnt_after [NL];
  logic [CW-1:0] count_nxt [NL];
  logic [mlfq_pkg::ID_W-1:0] cur_job_r;
  logic [WW-1:0] cur_rem_r;
  logic [LW-1:0] cur_lvl_r, sel_r, tgt;
  logic          cur_valid_r, all_empty, found;
  logic [LW-1:0] sel;
  logic          we;
  logic [mlfq_pkg::ADDR_W-1:0] waddr, raddr;
  logic [mlfq_pkg::ENTRY_W-1:0] wdata, rdata;
  logic [LW-1:0] wlvl;
  logic          do_push;
  logic [WW-1:0] work;
  logic          ov_r;
  mlfq_pkg::out_item_t out_r;
  mlfq_pkg::out_item_t out_init;

  assign q_pop        = (state_r == S_IDLE) && q_valid && (!ov_r || out_ch.ready);
  assign out_ch.valid = ov_r;
  assign out_ch.data  = out_r;

  always_comb begin
    all_empty = 1'b1;
    for (int l = 0; l < NL; l++) begin
      if (count_r[l] != '0) all_empty = 1'b0;
    end
    if (cur_lvl_r == '0 && all_empty) tgt = '0;
    else if (cur_lvl_r == LW'(NL - 1)) tgt = cur_lvl_r;
    else tgt = cur_lvl_r + 1'b1;
    if (q_data.req_type == mlfq_pkg::REQ_ARRIVAL) begin
      wlvl    = '0;
      do_push = 1'b1;
      wdata   = {q_data.job_id, q_data.service_demand};
    end else begin
      wlvl    = tgt;
      do_push = cur_valid_r && (cur_rem_r != '0);
      wdata   = {cur_job_r, cur_rem_r};
    end
    if (count_r[wlvl] == CW'(mlfq_pkg::MAX_JOBS)) do_push = 1'b0;
    we    = q_pop && do_push;
    waddr = {wlvl, SW'(head_r[wlvl] + SW'(count_r[wlvl]))};
    for (int l = 0; l < NL; l++) begin
      cnt_after[l] = count_r[l] + CW'(we && wlvl == LW'(l));
    end
    found = 1'b0;
    sel   = '0;
    for (int l = NL - 1; l >= 0; l--) begin
      if (cnt_after[l] != '0) begin
        found = 1'b1;
        sel   = LW'(l);
      end
    end
    for (int l = 0; l < NL; l++) begin
      count_nxt[l] = cnt_after[l];
    end
    if (q_data.req_type == mlfq_pkg::REQ_TICK && found) begin
      count_nxt[sel] = cnt_after[sel] - 1'b1;
    end
    out_init        = '0;
    out_init.status = we ? mlfq_pkg::ST_ACCEPT : mlfq_pkg::ST_DROP;
    raddr = {sel_r, head_r[sel_r]};
    work  = (rdata[WW-1:0] != '0) ? rdata[WW-1:0] - 1'b1 : '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_pop) state_nxt = S_READ;
      S_READ: state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  mlfq_ram #(.WIDTH(mlfq_pkg::ENTRY_W), .DEPTH(mlfq_pkg::DEPTH)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic tick_r, hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ov_r        <= 1'b0;
      cur_valid_r <= 1'b0;
      cur_job_r   <= '0;
      cur_rem_r   <= '0;
      cur_lvl_r   <= '0;
      for (int l = 0; l < NL; l++) begin
        head_r[l]  <= '0;
        count_r[l] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      if (q_pop) begin
        for (int l = 0; l < NL; l++) count_r[l] <= count_nxt[l];
        tick_r <= (q_data.req_type == mlfq_pkg::REQ_TICK);
        hit_r  <= found;
        sel_r  <= sel;
        out_r  <= out_init;
        if (q_data.req_type == mlfq_pkg::REQ_TICK && !found) begin
          cur_valid_r <= 1'b0;
          cur_job_r   <= '0;
          cur_rem_r   <= '0;
          cur_lvl_r   <= '0;
        end
      end
      if (state_r == S_READ && tick_r && hit_r) begin
        head_r[sel_r] <= head_r[sel_r] + 1'b1;
      end
      if (state_r == S_DONE) begin
        ov_r <= 1'b1;
        if (tick_r) begin
          if (hit_r) begin
            cur_valid_r <= 1'b1;
            cur_job_r   <= rdata[mlfq_pkg::ENTRY_W-1:WW];
            cur_rem_r   <= work;
            cur_lvl_r   <= sel_r;
            out_r.status         <= mlfq_pkg::ST_RAN;
            out_r.run_job        <= rdata[mlfq_pkg::ENTRY_W-1:WW];
            out_r.run_level      <= 2'(sel_r);
            out_r.remaining_work <= work;
            out_r.job_finished   <= (work == '0);
          end else begin
            out_r.status <= mlfq_pkg::ST_IDLE;
          end
        end
      end
    end
  end
endmodule

/* test/multilevel_feedback_queue_scheduler_test.sv */
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_test
// drives arrivals and ticks through random flow control and checks every
// result against an in-bench predictor of the four-level feedback scheduler
// ----------------------------------------------------------------------------
class sched_scoreboard;
  typedef logic [mlfq_pkg::ENTRY_W-1:0] entry_t;

  entry_t              queues[mlfq_pkg::NUM_LEVELS][$];
  logic [3:0]          cur_job;
  logic [15:0]         cur_work;
  int                  cur_level;
  bit                  cur_valid;
  mlfq_pkg::out_item_t pending[$];
  int                  errors;

  function void note_input(mlfq_pkg::in_item_t it);
    mlfq_pkg::out_item_t r;
    int tgt;
    bit empty;
    entry_t e;
    r = '0;
    if (it.req_type == mlfq_pkg::REQ_ARRIVAL) begin
      if (queues[0].size() < mlfq_pkg::MAX_JOBS) begin
        queues[0].push_back({it.job_id, it.service_demand});
        r.status = mlfq_pkg::ST_ACCEPT;
      end else begin
        r.status = mlfq_pkg::ST_DROP;
      end
      pending.push_back(r);
      return;
    end
    if (cur_valid && cur_work != 0) begin
      empty = 1;
      foreach (queues[l]) if (queues[l].size() != 0) empty = 0;
      if (cur_level == 0 && empty) tgt = 0;
      else if (cur_level + 1 >= mlfq_pkg::NUM_LEVELS) tgt = mlfq_pkg::NUM_LEVELS - 1;
      else tgt = cur_level + 1;
      if (queues[tgt].size() < mlfq_pkg::MAX_JOBS) queues[tgt].push_back({cur_job, cur_work});
    end
    r.status = mlfq_pkg::ST_IDLE;
    cur_valid = 0;
    cur_job = 0;
    cur_work = 0;
    cur_level = 0;
    for (int l = 0; l < mlfq_pkg::NUM_LEVELS; l++) begin
      if (queues[l].size() != 0) begin
        e = queues[l].pop_front();
        cur_job = e[19:16];
        cur_work = (e[15:0] != 0) ? e[15:0] - 16'd1 : 16'd0;
        cur_level = l;
        cur_valid = 1;
        r.status = mlfq_pkg::ST_RAN;
        r.run_job = cur_job;
        r.run_level = l[1:0];
        r.remaining_work = cur_work;
        r.job_finished = (cur_work == 0);
        break;
      end
    end
    pending.push_back(r);
  endfunction

  function void check_result(mlfq_pkg::out_item_t got);
    mlfq_pkg::out_item_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %p", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status || got.run_job !== want.run_job ||
        got.run_level !== want.run_level || got.remaining_work !== want.remaining_work ||
        got.job_finished !== want.job_finished) begin
      $display("%0t: mismatch expected %p actual %p", $time, want, got);
      errors++;
    end
  endfunction
endclass

module multilevel_feedback_queue_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_recv;

  mlfq_in_if  in_ch ();
  mlfq_out_if out_ch ();

  sched_scoreboard sb;

  multilevel_feedback_queue_scheduler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_item(mlfq_pkg::in_item_t it);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      do @(negedge clk);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic stop_input();
    in_ch.valid <= 0;
  endtask

  task automatic send_arrival(logic [3:0] id, logic [15:0] work);
    send_item({mlfq_pkg::REQ_ARRIVAL, id, work});
  endtask

  task automatic send_tick();
    send_item({mlfq_pkg::REQ_TICK, 4'($urandom), 16'($urandom)});
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // receiver
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  always @(negedge clk) begin
    out_ch.ready <= !hold_recv && !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  task automatic random_phase(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 45) send_tick();
      else if (k < 50) send_arrival(4'($urandom), 16'($urandom));
      else send_arrival(4'($urandom), 16'($urandom_range(1, 6)));
    end
    stop_input();
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
    hold_recv = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed
    send_tick();
    send_arrival(4'd0, 16'd0);
    send_arrival(4'd15, 16'hffff);
    send_arrival(4'd5, 16'd1);
    send_arrival(4'd10, 16'd3);
    repeat (8) send_tick();
    for (int i = 0; i < 17; i++) send_arrival(i[3:0], 16'd2);
    stop_input();
    drain();

    // long receiver stall while items keep coming
    fork
      begin
        hold_recv = 1;
        repeat (200) @(negedge clk);
        hold_recv = 0;
      end
      begin
        repeat (40) send_tick();
        stop_input();
      end
    join
    drain();

    send_idle_pct = 14;
    recv_idle_pct = 51;
    random_phase(560);
    drain();
    send_idle_pct = 51;
    recv_idle_pct = 14;
    random_phase(560);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(560);
    drain();
    repeat (20) @(negedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
